// File: hdl/critically_damped_smoother_3d_macros.svh
// Assertion macros for the critically damped smoother.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef CRITICALLY_DAMPED_SMOOTHER_3D_MACROS_SVH
`define CRITICALLY_DAMPED_SMOOTHER_3D_MACROS_SVH

// check a condition in the same cycle as its trigger
`define CDSM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cdsm: same-cycle check failed");

// check a condition in the cycle after its trigger
`define CDSM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cdsm: next-cycle check failed");

`endif

// File: hdl/cdsm_pkg.sv
// Shared types, constants and fixed-point helpers for the smoother.
// No dependencies; the datapath, controller, top level and testbench use it by scoped names.
package cdsm_pkg;

	localparam int FRAC_BITS = 16;

	localparam logic [35:0] ONE_FX = 36'(64'd1 << FRAC_BITS);
	localparam logic [33:0] UCAP = 34'(64'd1 << (2 * FRAC_BITS + 1));
	localparam logic [33:0] OMEGA_NUM = 34'(64'd1 << (2 * FRAC_BITS + 1));
	localparam logic [33:0] E_NUM = 34'(64'd1 << (2 * FRAC_BITS));
	localparam logic [33:0] C048 = 34'(((64'd48 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [33:0] C0235 = 34'(((64'd235 << FRAC_BITS) + 64'd500) / 64'd1000);
	localparam logic [23:0] EPS_RAW = 24'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);
	localparam logic [23:0] EPS = (EPS_RAW == 24'd0) ? 24'd1 : EPS_RAW;
	localparam logic signed [63:0] SLIM = 64'sh2000_0000_0000_0000;
	localparam logic signed [64:0] SLIM65 = 65'sh0_2000_0000_0000_0000;

	// register indexes
	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_STIME = 1'b1;

	typedef struct packed {
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic               target_valid;
		logic        [15:0] time_step;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] smoothed_x;
		logic signed [31:0] smoothed_y;
		logic signed [31:0] smoothed_z;
		logic               snapped;
	} out_item_t;

	typedef enum logic [3:0] {
		OP_OMEGA, OP_X, OP_X2, OP_X3, OP_A, OP_B, OP_E,
		OP_OC, OP_TEMP, OP_OT, OP_NV, OP_CD, OP_DOT
	} op_t;

	typedef struct packed {
		logic       load;
		logic       start;
		logic       finish;
		op_t        op;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic smooth;
		logic out_busy;
	} status_t;

	function automatic logic signed [63:0] slim(input logic signed [64:0] v);
		if (v > SLIM65) return SLIM;
		if (v < -SLIM65) return -SLIM;
		return v[63:0];
	endfunction

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] sa;
		logic signed [63:0] sb;
		sa = slim({a[63], a});
		sb = slim({b[63], b});
		return slim({sa[63], sa} + {sb[63], sb});
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -64'sh0000_0000_8000_0000) return -32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [63:0] absval(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	// signed product scaled by 2^-F, rounded toward minus infinity
	function automatic logic signed [63:0] smul_post(input logic [127:0] p, input logic neg);
		logic [63:0] q;
		if (p[127:64] != 64'd0) return neg ? -SLIM : SLIM;
		q = p[63:0] >> FRAC_BITS;
		if (neg && (p[FRAC_BITS-1:0] != '0)) q = q + 64'd1;
		return neg ? -$signed(q) : $signed(q);
	endfunction

	// unsigned product scaled by 2^-F, capped at UCAP
	function automatic logic [33:0] umul_post(input logic [127:0] p);
		logic [63:0] t;
		if (p[127:64] != 64'd0) return UCAP;
		t = p[63:0] >> FRAC_BITS;
		if (t > {30'd0, UCAP}) return UCAP;
		return t[33:0];
	endfunction

endpackage

// File: hdl/cdsm_mul.sv
// Sequential 64x64 unsigned multiplier, 16 multiplier bits per cycle.
// Uses no package; full 128-bit product valid with done.
module cdsm_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] p
);
	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [127:0] p_q;
	logic [1:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [79:0]  pp;
	logic [127:0] acc_next;

	// add one partial product at the top, shift the sum down
	assign pp = a_q * b_q[15:0];
	assign acc_next = (p_q >> 16) + {pp, 48'd0};

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (busy_q) begin
			p_q <= acc_next;
			b_q <= b_q >> 16;
		end
	end

	assign done = done_q;
	assign p = p_q;
endmodule

// File: hdl/cdsm_div.sv
// Restoring divider, one quotient bit per cycle, 34-bit quotient.
// Uses no package; quotient valid with done.
module cdsm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [33:0] num,
	input  logic [35:0] den,
	output logic        done,
	output logic [33:0] quo
);
	logic [33:0] n_q;
	logic [35:0] r_q;
	logic [35:0] d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [36:0] trial;
	logic        fits;

	// trial subtract of the shifted remainder
	assign trial = {r_q, n_q[33]};
	assign fits = trial >= {1'b0, d_q};

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd33) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			r_q <= fits ? 36'(trial - {1'b0, d_q}) : trial[35:0];
			n_q <= {n_q[32:0], fits};
		end
	end

	assign done = done_q;
	assign quo = n_q;
endmodule

// File: hdl/cdsm_datapath.sv
// Datapath: item registers, spring state, shared multiplier and divider.
// Depends on cdsm_pkg, cdsm_mul and cdsm_div.
module cdsm_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  cdsm_pkg::cmd_t      cmd,
	output cdsm_pkg::status_t   status,
	input  cdsm_pkg::in_item_t  in_data,
	input  logic                out_ready,
	output logic                out_valid,
	output cdsm_pkg::out_item_t out_data,
	input  logic                smoothing_enable,
	input  logic [23:0]         smooth_time
);
	logic signed [31:0] tgt_q [3];
	logic signed [31:0] pos_q [3];
	logic signed [31:0] spd_q [3];
	logic signed [31:0] nv_q [3];
	logic signed [31:0] cand_q [3];
	logic               valid_q;
	logic [15:0]        dt_q;
	logic               primed_q;
	logic [31:0]        omega_q;
	logic [33:0]        x_q;
	logic [33:0]        x2_q;
	logic [33:0]        x3_q;
	logic [33:0]        a_q;
	logic [33:0]        b_q;
	logic [16:0]        e_q;
	logic signed [63:0] oc_q;
	logic signed [63:0] temp_q;
	logic signed [63:0] ot_q;
	logic signed [69:0] dot_q;
	logic               neg_q;
	logic               out_valid_q;
	cdsm_pkg::out_item_t out_q;

	logic               mul_start;
	logic               div_start;
	logic               mul_done;
	logic               div_done;
	logic [127:0]       prod;
	logic [33:0]        quo;
	logic [33:0]        div_num;
	logic [35:0]        div_den;
	logic signed [63:0] sa;
	logic signed [63:0] sb;
	logic signed [32:0] change;
	logic signed [63:0] change_ext;
	logic signed [63:0] spd_ext;
	logic signed [63:0] tgt_ext;
	logic signed [63:0] sprod;
	logic [69:0]        dmag;
	logic signed [69:0] dterm;
	logic [23:0]        st_eff;
	logic               smooth_on;
	logic signed [31:0] new_pos [3];
	logic signed [31:0] new_spd [3];
	logic               new_snap;
	logic [1:0]         ax;

	assign ax = cmd.axis;
	assign smooth_on = smoothing_enable && (smooth_time != 24'd0);
	assign st_eff = (smooth_time < cdsm_pkg::EPS) ? cdsm_pkg::EPS : smooth_time;

	// per-axis terms for the current axis
	assign change = {pos_q[ax][31], pos_q[ax]} - {tgt_q[ax][31], tgt_q[ax]};
	assign change_ext = 64'(change);
	assign spd_ext = 64'(spd_q[ax]);
	assign tgt_ext = 64'(tgt_q[ax]);

	// select multiplier operands for each step
	always_comb begin
		sa = '0;
		sb = '0;
		case (cmd.op)
			cdsm_pkg::OP_X: begin
				sa = 64'(omega_q);
				sb = 64'(dt_q);
			end
			cdsm_pkg::OP_X2: begin
				sa = 64'(x_q);
				sb = 64'(x_q);
			end
			cdsm_pkg::OP_X3: begin
				sa = 64'(x2_q);
				sb = 64'(x_q);
			end
			cdsm_pkg::OP_A: begin
				sa = 64'(x2_q);
				sb = 64'(cdsm_pkg::C048);
			end
			cdsm_pkg::OP_B: begin
				sa = 64'(x3_q);
				sb = 64'(cdsm_pkg::C0235);
			end
			cdsm_pkg::OP_OC: begin
				sa = 64'(omega_q);
				sb = change_ext;
			end
			cdsm_pkg::OP_TEMP: begin
				sa = cdsm_pkg::sadd(spd_ext, oc_q);
				sb = 64'(dt_q);
			end
			cdsm_pkg::OP_OT: begin
				sa = 64'(omega_q);
				sb = temp_q;
			end
			cdsm_pkg::OP_NV: begin
				sa = cdsm_pkg::sadd(spd_ext, -ot_q);
				sb = 64'(e_q);
			end
			cdsm_pkg::OP_CD: begin
				sa = cdsm_pkg::sadd(change_ext, temp_q);
				sb = 64'(e_q);
			end
			cdsm_pkg::OP_DOT: begin
				sa = -change_ext;
				sb = 64'(cand_q[ax]) - tgt_ext;
			end
			default: begin
				sa = '0;
				sb = '0;
			end
		endcase
	end

	// dispatch to the divider or the multiplier
	always_comb begin
		div_start = 1'b0;
		div_num = cdsm_pkg::OMEGA_NUM;
		div_den = 36'(st_eff);
		case (cmd.op)
			cdsm_pkg::OP_OMEGA: div_start = cmd.start;
			cdsm_pkg::OP_E: begin
				div_start = cmd.start;
				div_num = cdsm_pkg::E_NUM;
				div_den = cdsm_pkg::ONE_FX + 36'(x_q) + 36'(a_q) + 36'(b_q);
			end
			default: div_start = 1'b0;
		endcase
	end
	assign mul_start = cmd.start && !div_start;

	cdsm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (cdsm_pkg::absval(sa)),
		.b      (cdsm_pkg::absval(sb)),
		.done   (mul_done),
		.p      (prod)
	);

	cdsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	assign sprod = cdsm_pkg::smul_post(prod, neg_q);
	assign dmag = prod[69:0];
	assign dterm = neg_q ? -$signed(dmag) : $signed(dmag);

	// final state for the item
	always_comb begin
		new_snap = 1'b0;
		for (int i = 0; i < 3; i++) begin
			new_pos[i] = pos_q[i];
			new_spd[i] = spd_q[i];
		end
		if (!valid_q || !smooth_on) begin
			for (int i = 0; i < 3; i++) new_pos[i] = tgt_q[i];
		end else if (dt_q != 16'd0) begin
			if (dot_q > 70'sd0) begin
				new_snap = 1'b1;
				for (int i = 0; i < 3; i++) begin
					new_pos[i] = tgt_q[i];
					new_spd[i] = '0;
				end
			end else begin
				for (int i = 0; i < 3; i++) begin
					new_pos[i] = cand_q[i];
					new_spd[i] = nv_q[i];
				end
			end
		end
		if (!valid_q) begin
			new_snap = 1'b0;
			for (int i = 0; i < 3; i++) new_spd[i] = '0;
		end
	end

	// control state: primed flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				primed_q <= valid_q;
			end
		end
	end

	// spring state, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				spd_q[i] <= '0;
			end
		end else if (cmd.load) begin
			if (!primed_q) begin
				pos_q[0] <= in_data.target_x;
				pos_q[1] <= in_data.target_y;
				pos_q[2] <= in_data.target_z;
			end
		end else if (cmd.finish) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= new_pos[i];
				spd_q[i] <= new_spd[i];
			end
		end
	end

	// latch the item and write back step results
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tgt_q[0] <= in_data.target_x;
			tgt_q[1] <= in_data.target_y;
			tgt_q[2] <= in_data.target_z;
			valid_q <= in_data.target_valid;
			dt_q <= in_data.time_step;
			dot_q <= '0;
		end
		if (mul_start) neg_q <= sa[63] ^ sb[63];
		if (div_done) begin
			case (cmd.op)
				cdsm_pkg::OP_OMEGA: omega_q <= quo[31:0];
				cdsm_pkg::OP_E: e_q <= quo[16:0];
				default: e_q <= e_q;
			endcase
		end
		if (mul_done) begin
			case (cmd.op)
				cdsm_pkg::OP_X: x_q <= cdsm_pkg::umul_post(prod);
				cdsm_pkg::OP_X2: x2_q <= cdsm_pkg::umul_post(prod);
				cdsm_pkg::OP_X3: x3_q <= cdsm_pkg::umul_post(prod);
				cdsm_pkg::OP_A: a_q <= cdsm_pkg::umul_post(prod);
				cdsm_pkg::OP_B: b_q <= cdsm_pkg::umul_post(prod);
				cdsm_pkg::OP_OC: oc_q <= sprod;
				cdsm_pkg::OP_TEMP: temp_q <= sprod;
				cdsm_pkg::OP_OT: ot_q <= sprod;
				cdsm_pkg::OP_NV: nv_q[ax] <= cdsm_pkg::sat32(sprod);
				cdsm_pkg::OP_CD: cand_q[ax] <= cdsm_pkg::sat32(cdsm_pkg::sadd(tgt_ext, sprod));
				cdsm_pkg::OP_DOT: dot_q <= dot_q + dterm;
				default: dot_q <= dot_q;
			endcase
		end
		if (cmd.finish) begin
			out_q.smoothed_x <= new_pos[0];
			out_q.smoothed_y <= new_pos[1];
			out_q.smoothed_z <= new_pos[2];
			out_q.snapped <= new_snap;
		end
	end

	assign status.done = mul_done || div_done;
	assign status.smooth = valid_q && smooth_on && (dt_q != 16'd0);
	assign status.out_busy = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
endmodule

// File: hdl/cdsm_ctrl.sv
// Controller: sequences the spring update steps over the shared units.
// Depends on cdsm_pkg.
module cdsm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output cdsm_pkg::cmd_t    cmd,
	input  cdsm_pkg::status_t status
);
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_CHECK  = 5'b00010,
		S_ISSUE  = 5'b00100,
		S_WAIT   = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t           state_q;
	cdsm_pkg::op_t    op_q;
	logic [1:0]       axis_q;
	cdsm_pkg::op_t    op_next;
	logic             last;

	// step order: shared terms first, then per-axis steps
	always_comb begin
		last = 1'b0;
		case (op_q)
			cdsm_pkg::OP_OMEGA: op_next = cdsm_pkg::OP_X;
			cdsm_pkg::OP_X: op_next = cdsm_pkg::OP_X2;
			cdsm_pkg::OP_X2: op_next = cdsm_pkg::OP_X3;
			cdsm_pkg::OP_X3: op_next = cdsm_pkg::OP_A;
			cdsm_pkg::OP_A: op_next = cdsm_pkg::OP_B;
			cdsm_pkg::OP_B: op_next = cdsm_pkg::OP_E;
			cdsm_pkg::OP_E: op_next = cdsm_pkg::OP_OC;
			cdsm_pkg::OP_OC: op_next = cdsm_pkg::OP_TEMP;
			cdsm_pkg::OP_TEMP: op_next = cdsm_pkg::OP_OT;
			cdsm_pkg::OP_OT: op_next = cdsm_pkg::OP_NV;
			cdsm_pkg::OP_NV: op_next = cdsm_pkg::OP_CD;
			cdsm_pkg::OP_CD: op_next = cdsm_pkg::OP_DOT;
			cdsm_pkg::OP_DOT: begin
				op_next = cdsm_pkg::OP_OC;
				last = (axis_q == 2'd2);
			end
			default: op_next = cdsm_pkg::OP_OMEGA;
		endcase
	end

	// state register and step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= cdsm_pkg::OP_OMEGA;
			axis_q <= 2'd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
						op_q <= cdsm_pkg::OP_OMEGA;
						axis_q <= 2'd0;
					end
				end
				S_CHECK: state_q <= status.smooth ? S_ISSUE : S_FINISH;
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (status.done) begin
						if (last) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_ISSUE;
							op_q <= op_next;
							if (op_q == cdsm_pkg::OP_DOT) axis_q <= axis_q + 2'd1;
						end
					end
				end
				S_FINISH: if (!status.out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign cmd.load = (state_q == S_IDLE) && in_valid;
	assign cmd.start = (state_q == S_ISSUE);
	assign cmd.finish = (state_q == S_FINISH) && !status.out_busy;
	assign cmd.op = op_q;
	assign cmd.axis = axis_q;
endmodule

// File: hdl/critically_damped_smoother_3d.sv
// Per item: one check state; when smoothed, two divides and 23 multiplies in turn on the
// shared units; then a finish state. Bypassed items go straight from check to finish.
// A new item is taken only after the last one has finished; the next item is taken while a
// result waits. Reset (arst_n low, asynchronous): position, speed and primed flag cleared,
// smoothing_enable = 0, smooth_time = 6554; no result pending.
module critically_damped_smoother_3d (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cdsm_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output cdsm_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	logic              en_q;
	logic [23:0]       st_q;
	logic              wr;
	cdsm_pkg::cmd_t    cmd;
	cdsm_pkg::status_t status;

	// configuration registers
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
			st_q <= 24'd6554;
		end else if (wr) begin
			case (paddr[2])
				cdsm_pkg::REG_ENABLE: en_q <= pwdata[0];
				cdsm_pkg::REG_STIME: st_q <= pwdata[23:0];
				default: en_q <= en_q;
			endcase
		end
	end

	assign prdata = (paddr[2] == cdsm_pkg::REG_STIME) ? {8'd0, st_q} : {31'd0, en_q};

	cdsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.status   (status)
	);

	cdsm_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.in_data          (in_data),
		.out_ready        (out_ready),
		.out_valid        (out_valid),
		.out_data         (out_data),
		.smoothing_enable (en_q),
		.smooth_time      (st_q)
	);

	`include "critically_damped_smoother_3d_macros.svh"

	// a step result never lands while a new step is launched
	`CDSM_ASSERT_NOW(a_done_not_start, status.done, !cmd.start)
	// a unit never finishes in the cycle after launch
	`CDSM_ASSERT_NEXT(a_start_no_done, cmd.start, !status.done)
	// an accepted item closes the input until its work is done
	`CDSM_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
endmodule

// File: verif/critically_damped_smoother_3d_tb.sv
// Self-checking testbench for the critically damped 3-D smoother.
// Depends on cdsm_pkg (item types) and the critically_damped_smoother_3d top level.
`timescale 1ns / 100ps

module critically_damped_smoother_3d_tb;

	localparam int F = 16;
	localparam longint LIM = 64'sh2000_0000_0000_0000;
	localparam longint UCAPV = 64'd1 << (2 * F + 1);
	localparam longint K048 = ((64'd48 << F) + 64'd50) / 64'd100;
	localparam longint K0235 = ((64'd235 << F) + 64'd500) / 64'd1000;
	localparam longint TEPS = ((64'd1 << F) + 64'd5000) / 64'd10000;
	localparam logic [2:0] ADDR_ENABLE = 3'd0;
	localparam logic [2:0] ADDR_STIME = 3'd4;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	cdsm_pkg::in_item_t in_data;
	cdsm_pkg::out_item_t out_data;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	critically_damped_smoother_3d uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow of the block's registers and state
	logic sh_enable;
	logic [23:0] sh_stime;
	longint sh_pos [3];
	longint sh_spd [3];
	bit sh_primed;

	cdsm_pkg::in_item_t pending_items [$];
	cdsm_pkg::out_item_t expected_points [$];
	int mismatches;
	int send_idle, recv_idle;
	bit hold_send;
	bit item_taken;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint clip61(longint v);
		if (v > LIM) return LIM;
		if (v < -LIM) return -LIM;
		return v;
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint fx_add(longint a, longint b);
		return clip61(clip61(a) + clip61(b));
	endfunction

	function automatic longint ufx_mul(longint a, longint b);
		logic [127:0] p;
		logic [127:0] t;
		p = 128'(a) * 128'(b);
		if (p[127:64] != 0) return UCAPV;
		t = p >> F;
		return (t > UCAPV) ? UCAPV : longint'(t[63:0]);
	endfunction

	// signed product scaled by 2^-F, floored
	function automatic longint sfx_mul(longint a, longint b);
		bit neg;
		logic [63:0] ma, mb, q;
		logic [127:0] p;
		neg = (a < 0) != (b < 0);
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		p = 128'(ma) * 128'(mb);
		if (p[127:64] != 0) return neg ? -LIM : LIM;
		q = p[63:0] >> F;
		if (neg && p[F-1:0] != 0) q = q + 1;
		if (q > LIM) q = LIM;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic cdsm_pkg::out_item_t smooth_point(cdsm_pkg::in_item_t it);
		cdsm_pkg::out_item_t r;
		longint tgt [3];
		longint cand [3], nv [3];
		longint st, om, x, x2, x3, den, e, change, temp;
		longint dt;
		logic signed [127:0] dot;
		bit snap;
		tgt[0] = longint'(it.target_x);
		tgt[1] = longint'(it.target_y);
		tgt[2] = longint'(it.target_z);
		dt = longint'(it.time_step);
		snap = 0;
		if (!sh_primed) begin
			for (int i = 0; i < 3; i++) sh_pos[i] = tgt[i];
			sh_primed = 1;
		end
		if (!sh_enable || sh_stime == 0) begin
			for (int i = 0; i < 3; i++) sh_pos[i] = tgt[i];
		end else if (dt != 0) begin
			st = (sh_stime < TEPS) ? TEPS : longint'(sh_stime);
			om = (64'd1 << (2 * F + 1)) / st;
			x = ufx_mul(om, dt);
			x2 = ufx_mul(x, x);
			x3 = ufx_mul(x2, x);
			den = (64'd1 << F) + x + ufx_mul(x2, K048) + ufx_mul(x3, K0235);
			e = (64'd1 << (2 * F)) / den;
			dot = 0;
			for (int i = 0; i < 3; i++) begin
				change = sh_pos[i] - tgt[i];
				temp = sfx_mul(fx_add(sh_spd[i], sfx_mul(om, change)), dt);
				nv[i] = clip32(sfx_mul(fx_add(sh_spd[i], -sfx_mul(om, temp)), e));
				cand[i] = clip32(fx_add(tgt[i], sfx_mul(fx_add(change, temp), e)));
				dot += 128'(tgt[i] - sh_pos[i]) * 128'(cand[i] - tgt[i]);
			end
			// overshoot: snap onto the target
			if (dot > 0) begin
				for (int i = 0; i < 3; i++) begin
					sh_pos[i] = tgt[i];
					sh_spd[i] = 0;
				end
				snap = 1;
			end else begin
				for (int i = 0; i < 3; i++) begin
					sh_pos[i] = cand[i];
					sh_spd[i] = nv[i];
				end
			end
		end
		if (!it.target_valid) begin
			for (int i = 0; i < 3; i++) begin
				sh_pos[i] = tgt[i];
				sh_spd[i] = 0;
			end
			sh_primed = 0;
			snap = 0;
		end
		r.smoothed_x = 32'(sh_pos[0]);
		r.smoothed_y = 32'(sh_pos[1]);
		r.smoothed_z = 32'(sh_pos[2]);
		r.snapped = snap;
		return r;
	endfunction

	// check results in order, predict each item on acceptance
	always @(posedge clk) begin
		item_taken <= arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", out_data);
			end else begin
				if (out_data !== expected_points[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h got %h", expected_points[0], out_data);
				end
				void'(expected_points.pop_front());
			end
		end
		if (arst_n && in_valid && in_ready) expected_points.push_back(smooth_point(in_data));
	end

	// drive the next item, hold it until accepted
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
			if (in_valid && !item_taken) begin
				// hold until accepted
			end else if (pending_items.size() != 0 && !hold_send
					&& $urandom_range(99) >= send_idle) begin
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= addr; pwdata <= data;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		if (addr == ADDR_ENABLE) sh_enable = data[0];
		else sh_stime = data[23:0];
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	function automatic cdsm_pkg::in_item_t rand_point(bit valid, bit wide);
		cdsm_pkg::in_item_t it;
		it.target_x = wide ? $urandom : $signed($urandom_range(2 << F)) - (1 << F);
		it.target_y = wide ? $urandom : $signed($urandom_range(2 << F)) - (1 << F);
		it.target_z = wide ? $urandom : $signed($urandom_range(2 << F)) - (1 << F);
		it.target_valid = valid;
		it.time_step = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3000));
		if ($urandom_range(19) == 0) it.time_step = 0;
		return it;
	endfunction

	// wait for the block to drain everything queued so far
	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_points.size() != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic queue_directed();
		cdsm_pkg::in_item_t it;
		int sgn [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF};
		for (int k = 0; k < 4; k++) begin
			it.target_x = sgn[k]; it.target_y = sgn[3-k]; it.target_z = sgn[k];
			it.target_valid = 1; it.time_step = (k == 2) ? 16'hFFFF : 16'd1092;
			pending_items.push_back(it);
		end
		it.time_step = 0; pending_items.push_back(it);
		it.target_valid = 0; pending_items.push_back(it);
		it.time_step = 16'hFFFF; pending_items.push_back(it);
		for (int k = 0; k < 6; k++) pending_items.push_back(rand_point(1, 0));
	endtask

	initial begin
		logic [23:0] times [6] = '{24'd6554, 24'd0, 24'd1, 24'hFFFFFF, 24'd3, 24'd30000};
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		sh_enable = 0; sh_stime = 24'd6554; sh_primed = 0;
		for (int i = 0; i < 3; i++) begin sh_pos[i] = 0; sh_spd[i] = 0; end
		mismatches = 0; send_idle = 34; recv_idle = 73; hold_send = 0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1;
		// reset settings first, with smoothing off
		queue_directed();
		drain();
		apb_write(ADDR_ENABLE, 32'hFFFF_FFFF);
		for (int ph = 0; ph < 6; ph++) begin
			apb_write(ADDR_STIME, {8'hA5, times[ph]});
			queue_directed();
			for (int n = 0; n < 90; n++)
				pending_items.push_back(rand_point($urandom_range(24) != 0,
					$urandom_range(7) == 0));
			if (ph == 2) begin send_idle = 73; recv_idle = 34; end
			if (ph == 4) begin send_idle = 0; recv_idle = 0; end
			if (ph == 3) begin
				// stall the sender until all results are back
				while (pending_items.size() > 50) @(posedge clk);
				hold_send = 1;
				while (in_valid || expected_points.size() != 0) @(posedge clk);
				hold_send = 0;
			end
			drain();
		end
		apb_write(ADDR_ENABLE, 32'd0);
		queue_directed();
		drain();
		if (mismatches == 0)
			$display("critically_damped_smoother_3d_tb: done, clean");
		else
			$display("critically_damped_smoother_3d_tb: done, errors");
		$finish;
	end

	initial begin
		#(12 * 1000000);
		$display("critically_damped_smoother_3d_tb: done, errors");
		$finish;
	end

endmodule
